FILE: design/rlp_pkg.sv
// Package for the radix literal parser: character codes, radix and lead-phase
// codes, the parser flag record and the digit decoder.
// Has no dependencies; used by rlp_step and radix_literal_parser.
package rlp_pkg;

   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_ONE        = 8'h31;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
   localparam logic [7:0] CHAR_LOWER_H    = 8'h68;
   localparam logic [7:0] CHAR_LOWER_B    = 8'h62;
   localparam logic [7:0] CHAR_LOWER_D    = 8'h64;
   localparam logic [7:0] CHAR_LOWER_X    = 8'h78;

   localparam int OUT_WIDTH = 64;

   typedef enum logic [2:0] {
      RADIX_DEC = 3'b001,
      RADIX_HEX = 3'b010,
      RADIX_BIN = 3'b100
   } radix_type;

   typedef enum logic [2:0] {
      LEAD_FIRST = 3'b001,
      LEAD_SKIP  = 3'b010,
      LEAD_BODY  = 3'b100
   } lead_type;

   typedef struct packed {
      radix_type radix;
      lead_type  lead;
      logic      awaiting_letter;
      logic      need_digit;
      logic      negative;
      logic      prev_zero;
      logic      error_seen;
   } flags_type;

   localparam flags_type FLAGS_RESET = '{
      radix:           RADIX_DEC,
      lead:            LEAD_FIRST,
      awaiting_letter: 1'b0,
      need_digit:      1'b0,
      negative:        1'b0,
      prev_zero:       1'b0,
      error_seen:      1'b0
   };

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic digit_type digit_of(input logic [7:0] c, input radix_type radix);
      digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      case (radix)
         RADIX_HEX: begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               d.valid = 1'b1;
               d.value = 4'(c - CHAR_ZERO);
            end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
               d.valid = 1'b1;
               d.value = 4'(c - CHAR_LOWER_A + 8'd10);
            end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
               d.valid = 1'b1;
               d.value = 4'(c - CHAR_UPPER_A + 8'd10);
            end
         end
         RADIX_BIN: begin
            if (c == CHAR_ZERO || c == CHAR_ONE) begin
               d.valid = 1'b1;
               d.value = 4'(c - CHAR_ZERO);
            end
         end
         default: begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               d.valid = 1'b1;
               d.value = 4'(c - CHAR_ZERO);
            end
         end
      endcase
      return d;
   endfunction

endpackage

FILE: design/radix_literal_parser.sv
// Top level of the radix literal parser: input register, parser state and
// result register around the rlp_step logic.
// Depends on rlp_pkg and rlp_step.
//
// The parser takes one character per word on req and gives one result word on
// rsp for each word that has req_tlast set. It accepts a word in every cycle,
// and the end word waits in the input register while the final value is
// formed from the accumulator and then caught in the result register. Input
// stalls only when an end word meets a result that rsp has not yet taken. The
// accumulator is VALUE_WIDTH bits wide and wraps; the result is sign-extended
// to 64 bits, or all ones on an error.
module radix_literal_parser
   import rlp_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] char_code
   input  logic                 req_tlast,   // is_end
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [OUT_WIDTH-1:0] rsp_tdata,   // [63:0] value
   output logic [0:0]           rsp_tuser    // [0] parse_error
);

   logic                         in_valid_ff;
   logic [7:0]                   in_char_ff;
   logic                         in_end_ff;
   flags_type                    flags_ff;
   flags_type                    flags_in;
   logic [VALUE_WIDTH-1:0]       acc_ff;
   logic [VALUE_WIDTH-1:0]       acc_in;
   logic                         rsp_valid_ff;
   logic signed [OUT_WIDTH-1:0]  rsp_value_ff;
   logic signed [OUT_WIDTH-1:0]  rsp_value_in;
   logic                         rsp_error_ff;
   logic                         rsp_error_in;
   logic                         advance;
   logic                         req_accept;

   assign advance    = in_valid_ff & ~(in_end_ff & rsp_valid_ff & ~rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   rlp_step #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_step (
      .flags       (flags_ff),
      .acc         (acc_ff),
      .char_code   (in_char_ff),
      .is_end      (in_end_ff),
      .flags_next  (flags_in),
      .acc_next    (acc_in),
      .value       (rsp_value_in),
      .parse_error (rsp_error_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_char_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= FLAGS_RESET;
         acc_ff   <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_end_ff) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_error_ff;

endmodule

FILE: design/rlp_step.sv
// Combinational step of the radix literal parser: next flags and accumulator
// for one character, and the final value and error flag on an end word.
// Depends on rlp_pkg.
module rlp_step
   import rlp_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  flags_type                    flags,
   input  logic [VALUE_WIDTH-1:0]       acc,
   input  logic [7:0]                   char_code,
   input  logic                         is_end,
   output flags_type                    flags_next,
   output logic [VALUE_WIDTH-1:0]       acc_next,
   output logic signed [OUT_WIDTH-1:0]  value,
   output logic                         parse_error
);

   digit_type                     digit;
   logic                          body;
   logic [VALUE_WIDTH-1:0]        scaled;
   logic [VALUE_WIDTH-1:0]        magnitude;
   logic signed [VALUE_WIDTH-1:0] signed_value;

   assign digit = digit_of(char_code, flags.radix);

   always_comb begin
      case (flags.radix)
         RADIX_HEX: scaled = acc << 4;
         RADIX_BIN: scaled = acc << 1;
         default:   scaled = (acc << 3) + (acc << 1);
      endcase
   end

   always_comb begin
      parse_error  = flags.error_seen | flags.awaiting_letter | flags.need_digit;
      magnitude    = flags.negative ? (~acc + 1'b1) : acc;
      signed_value = signed'(magnitude);
      value        = parse_error ? '1 : OUT_WIDTH'(signed_value);
   end

   always_comb begin
      flags_next = flags;
      acc_next   = acc;
      body       = 1'b1;
      if (is_end) begin
         flags_next = FLAGS_RESET;
         acc_next   = '0;
         body       = 1'b0;
      end else begin
         case (flags.lead)
            LEAD_FIRST: begin
               if (char_code == CHAR_MINUS) begin
                  flags_next.negative = 1'b1;
                  flags_next.lead     = LEAD_SKIP;
                  body                = 1'b0;
               end else begin
                  flags_next.lead = LEAD_BODY;
               end
            end
            LEAD_SKIP: begin
               if (char_code == CHAR_SPACE) begin
                  body = 1'b0;
               end else begin
                  flags_next.lead = LEAD_BODY;
               end
            end
            default: begin
               body = 1'b1;
            end
         endcase
      end

      if (body) begin
         if (char_code == CHAR_APOSTROPHE) begin
            acc_next                   = '0;
            flags_next.error_seen      = 1'b0;
            flags_next.radix           = RADIX_DEC;
            flags_next.awaiting_letter = 1'b1;
            flags_next.need_digit      = 1'b0;
            flags_next.prev_zero       = 1'b0;
         end else if (char_code == CHAR_LOWER_X && flags.prev_zero) begin
            acc_next                   = '0;
            flags_next.error_seen      = 1'b0;
            flags_next.radix           = RADIX_HEX;
            flags_next.awaiting_letter = 1'b0;
            flags_next.need_digit      = 1'b1;
            flags_next.prev_zero       = 1'b0;
         end else begin
            if (flags.awaiting_letter) begin
               flags_next.awaiting_letter = 1'b0;
               if (char_code == CHAR_LOWER_H) begin
                  flags_next.radix      = RADIX_HEX;
                  flags_next.need_digit = 1'b1;
               end else if (char_code == CHAR_LOWER_B) begin
                  flags_next.radix      = RADIX_BIN;
                  flags_next.need_digit = 1'b1;
               end else if (char_code == CHAR_LOWER_D) begin
                  flags_next.radix      = RADIX_DEC;
                  flags_next.need_digit = 1'b1;
               end else begin
                  flags_next.error_seen = 1'b1;
               end
            end else if (!digit.valid) begin
               flags_next.error_seen = 1'b1;
            end else begin
               acc_next              = scaled + VALUE_WIDTH'(digit.value);
               flags_next.need_digit = 1'b0;
            end
            flags_next.prev_zero = (char_code == CHAR_ZERO);
         end
      end
   end

endmodule
